>>> hw/rtl/ntm_pkg.sv
// Shared types and constants for the nearest timestamp matcher.
`default_nettype none

package ntm_pkg;

    // Field widths fixed by the interface
    localparam int TIME_W  = 63;
    localparam int SEQ_W   = 32;
    localparam int LIMIT_W = 7;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MATCH_DIFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LIMIT   = 2'd2;

    // Configuration reset values
    localparam logic [TIME_W-1:0]  RST_MAX_MATCH_DIFF = 63'd200000000;
    localparam logic [TIME_W-1:0]  RST_MAX_AGE        = 63'd1000000000;
    localparam logic [LIMIT_W-1:0] RST_BUFFER_LIMIT   = 7'd40;

    // Operation codes
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_MATCHED  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_TOO_FAR  = 2'd2;

    typedef struct packed {
        logic              operation;
        logic [TIME_W-1:0] event_time;
        logic [SEQ_W-1:0]  event_seq;
        logic [TIME_W-1:0] now_time;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [TIME_W-1:0] match_time;
        logic [SEQ_W-1:0]  match_seq;
        logic [TIME_W-1:0] match_distance;
    } t_out;

    // One stored reference
    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [SEQ_W-1:0]  seq;
    } t_entry;

    // Qualifiers travelling with memory read data into the scan pipeline
    typedef struct packed {
        logic vld;
        logic first;
    } t_scan_ctl;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_LIMIT,
        ST_AGE_RD,
        ST_AGE_CHK,
        ST_Q_SCAN,
        ST_Q_WAIT1,
        ST_Q_WAIT2,
        ST_Q_DONE
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/ntm_ref_mem.sv
// Reference stamp store: one write port, one registered read port.
`default_nettype none

module ntm_ref_mem #(
    parameter int DEPTH = 64,
    parameter int IW    = 6
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_we,
    input  wire logic [IW-1:0]         i_waddr,
    input  wire ntm_pkg::t_entry       i_wdata,
    input  wire logic                  i_re,
    input  wire logic [IW-1:0]         i_raddr,
    output ntm_pkg::t_entry            o_rdata
);
    import ntm_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/ntm_scan.sv
// Nearest-stamp search pipeline: distance stage then running-best stage.
`default_nettype none

module ntm_scan (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ntm_pkg::t_scan_ctl          i_ctl,
    input  wire ntm_pkg::t_entry             i_rdata,
    input  wire logic [ntm_pkg::TIME_W-1:0]  i_query_time,
    output ntm_pkg::t_entry                  o_best,
    output logic [ntm_pkg::TIME_W-1:0]       o_best_dist
);
    import ntm_pkg::*;

    logic [TIME_W:0]   w_fwd;
    logic [TIME_W-1:0] w_rev;
    logic [TIME_W-1:0] n_d;

    logic              r_s1_vld;
    logic              r_s1_first;
    logic [TIME_W-1:0] r_s1_d;
    t_entry            r_s1_entry;

    t_entry            r_best;
    logic [TIME_W-1:0] r_best_d;

    // Absolute distance between query and stored stamp
    always_comb begin
        w_fwd = {1'b0, i_query_time} - {1'b0, i_rdata.stamp};
        w_rev = i_rdata.stamp - i_query_time;
        n_d   = w_fwd[TIME_W] ? w_rev : w_fwd[TIME_W-1:0];
    end

    // Register distance with its entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_s1_first <= 1'b0;
        end else begin
            r_s1_vld   <= i_ctl.vld;
            r_s1_first <= i_ctl.first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_d     <= n_d;
        r_s1_entry <= i_rdata;
    end

    // Keep the strictly nearer entry, so the oldest wins a tie
    always_ff @(posedge i_clk) begin
        if (r_s1_vld && (r_s1_first || (r_s1_d < r_best_d))) begin
            r_best   <= r_s1_entry;
            r_best_d <= r_s1_d;
        end
    end

    assign o_best      = r_best;
    assign o_best_dist = r_best_d;

endmodule

`default_nettype wire

>>> hw/rtl/nearest_timestamp_matcher.sv
// Top level of the nearest timestamp matcher: control, configuration, result register.
//
// Input channel (i_in_valid / o_in_ready) carries one push or query per transfer.
// A push stores a reference stamp and sequence number in a circular store of
// DEPTH entries, trims the store to buffer_limit and then drops stale entries
// from the front. A push gives no result; each entry dropped for age costs one
// memory read and check.
// A query scans the stored entries from oldest to newest through the one read
// port of the store, one entry per cycle, and gives one result on the output
// channel (o_out_valid / i_out_ready) once the output register is free; a
// query on an empty store skips the scan.
// The input channel takes a new item only when the previous one is finished.
// A finished result waits in the output register; while the receiver stalls,
// pushes are still taken, and a query waits at its end for the register.
// The configuration port writes one register per cycle with i_cfg_we.
// Reset (i_rst_n low, synchronous) empties the store and restores the
// register defaults; the store itself needs no clearing pass.
`default_nettype none

module nearest_timestamp_matcher #(
    parameter int DEPTH = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire ntm_pkg::t_in                  i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output ntm_pkg::t_out                      o_out_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [ntm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ntm_pkg::TIME_W-1:0]    i_cfg_data
);
    import ntm_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = IW + 1;
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

    // Circular index advance; offset never exceeds DEPTH
    function automatic logic [IW-1:0] wrap(input logic [IW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    t_state            r_state, n_state;
    t_in               r_in;
    logic [IW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_k, n_k;
    t_scan_ctl         r_rd_ctl, n_rd_ctl;
    logic              r_out_vld;
    t_out              r_out;

    logic [TIME_W-1:0]  r_max_match_diff;
    logic [TIME_W-1:0]  r_max_age;
    logic [LIMIT_W-1:0] r_buffer_limit;

    logic              w_accept;
    logic              w_load;
    logic [CW-1:0]     w_limit;
    logic [LW-1:0]     w_bl_ext;
    logic              w_full;
    logic [IW-1:0]     w_head1;
    logic [CW-1:0]     w_count1;
    logic [TIME_W:0]   w_age;
    logic              w_stale;

    logic              w_we;
    logic [IW-1:0]     w_waddr;
    t_entry            w_wdata;
    logic              w_re;
    logic [IW-1:0]     w_raddr;
    t_entry            w_rdata;
    t_entry            w_best;
    logic [TIME_W-1:0] w_best_d;
    t_out              n_out;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_load   = (r_state == ST_Q_DONE) && (!r_out_vld || i_out_ready);

    // Effective limit, saturated to the store depth
    always_comb begin
        w_bl_ext = LW'(r_buffer_limit);
        w_limit  = (w_bl_ext > LW'(DEPTH)) ? CW'(DEPTH) : w_bl_ext[CW-1:0];
    end

    // Make room in a full store before the append
    always_comb begin
        w_full   = (r_count == CW'(DEPTH));
        w_head1  = w_full ? wrap(r_head, CW'(1)) : r_head;
        w_count1 = w_full ? (r_count - CW'(1)) : r_count;
    end

    // Age of the oldest entry; stamps newer than now never go stale
    always_comb begin
        w_age   = {1'b0, r_in.now_time} - {1'b0, w_rdata.stamp};
        w_stale = !w_age[TIME_W] && (w_age[TIME_W-1:0] > r_max_age);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.operation == OP_PUSH) begin
                        n_state = ST_PUSH;
                    end else if (r_count == '0) begin
                        n_state = ST_Q_DONE;
                    end else begin
                        n_state = ST_Q_SCAN;
                    end
                end
            end
            ST_PUSH:    n_state = ST_LIMIT;
            ST_LIMIT:   n_state = ST_AGE_RD;
            ST_AGE_RD: begin
                n_state = (r_count == '0) ? ST_IDLE : ST_AGE_CHK;
            end
            ST_AGE_CHK: n_state = w_stale ? ST_AGE_RD : ST_IDLE;
            ST_Q_SCAN: begin
                if (r_k == (r_count - CW'(1))) begin
                    n_state = ST_Q_WAIT1;
                end
            end
            ST_Q_WAIT1: n_state = ST_Q_WAIT2;
            ST_Q_WAIT2: n_state = ST_Q_DONE;
            ST_Q_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // Datapath and memory control per state
    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_k      = r_k;
        n_rd_ctl = '0;
        w_we     = 1'b0;
        w_waddr  = wrap(w_head1, w_count1);
        w_wdata  = '{stamp: r_in.event_time, seq: r_in.event_seq};
        w_re     = 1'b0;
        w_raddr  = r_head;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                n_k        = '0;
            end
            ST_PUSH: begin
                w_we    = 1'b1;
                n_head  = w_head1;
                n_count = w_count1 + CW'(1);
            end
            ST_LIMIT: begin
                if (r_count > w_limit) begin
                    n_head  = wrap(r_head, r_count - w_limit);
                    n_count = w_limit;
                end
            end
            ST_AGE_RD: begin
                w_re = (r_count != '0);
            end
            ST_AGE_CHK: begin
                if (w_stale) begin
                    n_head  = wrap(r_head, CW'(1));
                    n_count = r_count - CW'(1);
                end
            end
            ST_Q_SCAN: begin
                w_re     = 1'b1;
                w_raddr  = wrap(r_head, r_k);
                n_rd_ctl = '{vld: 1'b1, first: (r_k == '0)};
                n_k      = r_k + CW'(1);
            end
            default: begin
            end
        endcase
    end

    // Result word
    always_comb begin
        n_out = '0;
        if (r_count == '0) begin
            n_out.status = STATUS_EMPTY;
        end else if (w_best_d > r_max_match_diff) begin
            n_out.status         = STATUS_TOO_FAR;
            n_out.match_distance = w_best_d;
        end else begin
            n_out.status         = STATUS_MATCHED;
            n_out.match_time     = w_best.stamp;
            n_out.match_seq      = w_best.seq;
            n_out.match_distance = w_best_d;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_k       <= '0;
            r_rd_ctl  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_k      <= n_k;
            r_rd_ctl <= n_rd_ctl;
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Hold the accepted item and the pending result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
        if (w_load) begin
            r_out <= n_out;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_match_diff <= RST_MAX_MATCH_DIFF;
            r_max_age        <= RST_MAX_AGE;
            r_buffer_limit   <= RST_BUFFER_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_MATCH_DIFF: r_max_match_diff <= i_cfg_data;
                CFG_MAX_AGE:        r_max_age        <= i_cfg_data;
                CFG_BUFFER_LIMIT:   r_buffer_limit   <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    ntm_ref_mem #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ntm_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (r_rd_ctl),
        .i_rdata      (w_rdata),
        .i_query_time (r_in.event_time),
        .o_best       (w_best),
        .o_best_dist  (w_best_d)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
